### sv/mrfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

    localparam int MAX_FRAME_LEN   = 256;
    localparam int MIN_FRAME_LEN   = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [8:0]  COUNT_SAT        = 9'd511;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  BROADCAST_ADDR   = 8'h00;
    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [7:0]  CRC_BYTES_PLUS_ADDR = 8'd3;

    // register index, taken from paddr[2]
    localparam logic REG_SLAVE_ADDR = 1'b0;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_OTHER    = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_CRC_ERR  = 2'd3
    } frame_status_t;

    // classified frame, front to back
    typedef struct packed {
        frame_status_t status;
        logic [7:0]    payload_length;
        logic          is_broadcast;
    } frame_class_t;

endpackage

`default_nettype wire

### sv/mrfc_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface mrfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  payload_length;
    logic        is_broadcast;
    logic [15:0] bus_msg_count;
    logic [15:0] slave_msg_count;
    logic [15:0] bus_err_count;

    modport source (
        output valid, output frame_status, output payload_length, output is_broadcast,
        output bus_msg_count, output slave_msg_count, output bus_err_count,
        input ready
    );
    modport sink (
        input valid, input frame_status, input payload_length, input is_broadcast,
        input bus_msg_count, input slave_msg_count, input bus_err_count,
        output ready
    );
endinterface

`default_nettype wire

### sv/mrfc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfc_front
    import mrfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    mrfc_byte_if.sink         frame_in,
    input  wire logic [7:0]   slave_address,
    input  wire logic         queue_full,
    output logic              push,
    output frame_class_t      push_data
);

    logic [15:0] crc_reg, crc_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  tail_reg, tail_next;     // most recent byte
    logic [15:0] hist_reg, hist_next;     // CRC before the most recent byte

    logic        accept;
    logic [7:0]  addr_cur;
    logic [15:0] crc_upd;
    logic [8:0]  count_inc;
    logic        len_err;
    logic        crc_err;
    logic        match;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    assign frame_in.ready = !queue_full;
    assign accept         = frame_in.valid && frame_in.ready;

    always_comb
    begin
        addr_cur  = (count_reg == 9'd0) ? frame_in.data_byte : addr_reg;
        crc_upd   = crc_byte(crc_reg, frame_in.data_byte);
        count_inc = (count_reg < COUNT_SAT) ? count_reg + 9'd1 : count_reg;

        len_err = (count_inc < 9'(MIN_FRAME_LEN)) || (count_inc > 9'(MAX_FRAME_LEN));
        // trailer: low byte first, high byte last
        crc_err = hist_reg != {frame_in.data_byte, tail_reg};
        match   = (addr_cur == BROADCAST_ADDR) || (addr_cur == slave_address);

        push_data.is_broadcast   = addr_cur == BROADCAST_ADDR;
        push_data.payload_length = 8'h00;
        if (len_err)
        begin
            push_data.status = ST_LEN_ERR;
        end
        else if (crc_err)
        begin
            push_data.status = ST_CRC_ERR;
        end
        else if (match)
        begin
            push_data.status         = ST_ACCEPTED;
            push_data.payload_length = count_inc[7:0] - CRC_BYTES_PLUS_ADDR;
        end
        else
        begin
            push_data.status = ST_OTHER;
        end

        push = accept && frame_in.frame_end;

        crc_next   = crc_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        tail_next  = tail_reg;
        hist_next  = hist_reg;
        if (accept)
        begin
            if (frame_in.frame_end)
            begin
                crc_next   = CRC_INIT;
                count_next = 9'd0;
                addr_next  = 8'h00;
                tail_next  = 8'h00;
                hist_next  = CRC_INIT;
            end
            else
            begin
                crc_next   = crc_upd;
                count_next = count_inc;
                addr_next  = addr_cur;
                tail_next  = frame_in.data_byte;
                hist_next  = crc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= 9'd0;
            addr_reg  <= 8'h00;
            tail_reg  <= 8'h00;
            hist_reg  <= CRC_INIT;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            tail_reg  <= tail_next;
            hist_reg  <= hist_next;
        end
    end

endmodule

`default_nettype wire

### sv/mrfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfc_queue
    import mrfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire frame_class_t push_data,
    output logic              full,
    output logic              pop_valid,
    input  wire logic         pop,
    output frame_class_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    frame_class_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = fill_reg == CNT_W'(DEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/mrfc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfc_back
    import mrfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    input  wire frame_class_t pop_data,
    output logic              pop,
    mrfc_result_if.source     result_out
);

    logic [15:0] bus_cnt_reg, bus_cnt_next;
    logic [15:0] slv_cnt_reg, slv_cnt_next;
    logic [15:0] err_cnt_reg, err_cnt_next;
    logic        out_valid_reg, out_valid_next;
    frame_class_t out_reg;

    assign pop = pop_valid && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        bus_cnt_next   = bus_cnt_reg;
        slv_cnt_next   = slv_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        if (pop)
        begin
            out_valid_next = 1'b1;
            case (pop_data.status)
                ST_ACCEPTED:
                begin
                    bus_cnt_next = bus_cnt_reg + 16'd1;
                    slv_cnt_next = slv_cnt_reg + 16'd1;
                end
                ST_OTHER:
                begin
                    bus_cnt_next = bus_cnt_reg + 16'd1;
                end
                ST_LEN_ERR, ST_CRC_ERR:
                begin
                    err_cnt_next = err_cnt_reg + 16'd1;
                end
                default:
                begin
                    err_cnt_next = err_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_cnt_reg   <= 16'd0;
            slv_cnt_reg   <= 16'd0;
            err_cnt_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bus_cnt_reg   <= bus_cnt_next;
            slv_cnt_reg   <= slv_cnt_next;
            err_cnt_reg   <= err_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= pop_data;
        end
    end

    // counters already hold this frame's update while the result is shown
    assign result_out.valid           = out_valid_reg;
    assign result_out.frame_status    = out_reg.status;
    assign result_out.payload_length  = out_reg.payload_length;
    assign result_out.is_broadcast    = out_reg.is_broadcast;
    assign result_out.bus_msg_count   = bus_cnt_reg;
    assign result_out.slave_msg_count = slv_cnt_reg;
    assign result_out.bus_err_count   = err_cnt_reg;

endmodule

`default_nettype wire

### sv/modbus_rtu_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU frame checker, receive side.
// frame_in: one received byte per request (valid/ready), address byte first, CRC low
//   then CRC high last; frame_end marks the last byte of a frame.
// result_out: one request per frame: status, payload length, broadcast flag and the
//   three wrapping 16-bit counters (bus messages, slave messages, bus errors) as they
//   stand after this frame.
// APB port: register 0 (byte address 0) is slave_address, reset value 1.
// Throughput: one byte per cycle while the queue is not full; the CRC step over one byte is combinational.
// Result path: the front registers the class of the frame_end byte into the queue,
//   then the back loads it into the output register, where the result shows.
// Frames are independent; the queue between front and back holds QUEUE_DEPTH
//   classified frames, so bytes keep flowing while the receiver stalls until the
//   queue and the output register are all full, then frame_in.ready drops.
// Reset (rst_n, async, active low) clears the frame state (CRC 0xFFFF, count 0),
//   the counters, the queue and the output valid; slave_address returns to 1.
module modbus_rtu_frame_checker
    import mrfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    mrfc_byte_if.sink        frame_in,
    mrfc_result_if.source    result_out
);

    logic [7:0]   slave_addr_reg, slave_addr_next;
    logic         q_full;
    logic         q_push;
    frame_class_t q_push_data;
    logic         q_pop_valid;
    logic         q_pop;
    frame_class_t q_pop_data;

    // APB: no wait states; register decode on the word index only
    assign pready = 1'b1;

    always_comb
    begin
        slave_addr_next = slave_addr_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_SLAVE_ADDR))
        begin
            slave_addr_next = pwdata[7:0];
        end
        prdata = (paddr[2] == REG_SLAVE_ADDR) ? {24'h000000, slave_addr_reg} : 32'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
        end
    end

    // front: running CRC, byte count and address; classifies each frame at its end
    mrfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_in      (frame_in),
        .slave_address (slave_addr_reg),
        .queue_full    (q_full),
        .push          (q_push),
        .push_data     (q_push_data)
    );

    // queue of classified frames
    mrfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_pop_valid),
        .pop       (q_pop),
        .pop_data  (q_pop_data)
    );

    // back: counter updates and the output register
    mrfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop        (q_pop),
        .result_out (result_out)
    );

endmodule

`default_nettype wire
